[design/mer_pkg.sv]
// ----------------------------------------------------------------------------
// mer_pkg
// Shared types and codes for the midpoint ellipse rasterizer: controller to
// datapath command and status structs, multiplier operand and writeback codes.
// ----------------------------------------------------------------------------
package mer_pkg;

  // width of the plotted coordinates
  localparam int PIX_W = 12;

  // multiplier operand pair select
  localparam int MUL_SEL_W = 3;
  localparam logic [MUL_SEL_W-1:0] MUL_RXRX   = 3'd0;  // rx * rx
  localparam logic [MUL_SEL_W-1:0] MUL_RYRY   = 3'd1;  // ry * ry
  localparam logic [MUL_SEL_W-1:0] MUL_RX2RY  = 3'd2;  // rx^2 * ry
  localparam logic [MUL_SEL_W-1:0] MUL_AA     = 3'd3;  // (2x+1)^2
  localparam logic [MUL_SEL_W-1:0] MUL_RY2P   = 3'd4;  // ry^2 * product
  localparam logic [MUL_SEL_W-1:0] MUL_BB     = 3'd5;  // (y-1)^2
  localparam logic [MUL_SEL_W-1:0] MUL_RX2P   = 3'd6;  // rx^2 * product
  localparam logic [MUL_SEL_W-1:0] MUL_RX2RY2 = 3'd7;  // rx^2 * ry^2

  // writeback of the product register
  localparam int WR_SEL_W = 4;
  localparam logic [WR_SEL_W-1:0] WR_NONE      = 4'd0;
  localparam logic [WR_SEL_W-1:0] WR_RX2       = 4'd1;  // rx^2 <= p
  localparam logic [WR_SEL_W-1:0] WR_RY2       = 4'd2;  // ry^2 <= p
  localparam logic [WR_SEL_W-1:0] WR_START_ACC = 4'd3;  // cross_y, start numerator
  localparam logic [WR_SEL_W-1:0] WR_ACC_P     = 4'd4;  // acc <= p
  localparam logic [WR_SEL_W-1:0] WR_ACC_ADD   = 4'd5;  // acc += 4p
  localparam logic [WR_SEL_W-1:0] WR_ACC_FIN   = 4'd6;  // acc += 2 - 4p
  localparam logic [WR_SEL_W-1:0] WR_DEC       = 4'd7;  // decision <= acc / 4
  localparam logic [WR_SEL_W-1:0] WR_DEC_R2    = 4'd8;  // same, enter region 2

  typedef struct packed {
    logic                 load_start;
    logic                 do_step;
    logic [MUL_SEL_W-1:0] mul_sel;
    logic [WR_SEL_W-1:0]  wr_sel;
    logic                 upd_active;
    logic [1:0]           pt_idx;
  } mer_cmd_t;

  typedef struct packed {
    logic active;
    logic switch_req;
    logic done;
  } mer_sts_t;

endpackage

[design/mer_dp.sv]
// ----------------------------------------------------------------------------
// mer_dp
// Datapath: walk registers, shared multiplier with registered product,
// decision accumulator and the four-way point generator.
// ----------------------------------------------------------------------------
module mer_dp import mer_pkg::*; #(
  parameter int RADIUS_BITS = 8,
  parameter int COORD_BITS  = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [COORD_BITS-1:0]  in_center_x,
  input  logic [COORD_BITS-1:0]  in_center_y,
  input  logic [RADIUS_BITS-1:0] in_radius_x,
  input  logic [RADIUS_BITS-1:0] in_radius_y,
  input  mer_cmd_t               cmd,
  output mer_sts_t               sts,
  output logic signed [PIX_W-1:0] out_pixel_x,
  output logic signed [PIX_W-1:0] out_pixel_y,
  output logic                   out_last_point,
  output logic                   out_ellipse_done
);

  localparam int R     = RADIUS_BITS;
  localparam int SX_W  = R + 1;
  localparam int SQ_W  = 2 * R;
  localparam int CR_W  = 3 * R + 2;
  localparam int DEC_W = 4 * R + 4;
  localparam int ACC_W = 4 * R + 8;
  localparam int MA_W  = 2 * R + 4;
  localparam int MB_W  = 2 * R;
  localparam int P_W   = MA_W + MB_W;
  localparam int OXW   = SX_W + 2;
  localparam int MXW   = (COORD_BITS > OXW) ? COORD_BITS : OXW;
  localparam int EXT_W = ((MXW > PIX_W) ? MXW : PIX_W) + 1;
  localparam logic signed [ACC_W-1:0] ACC_TWO   = ACC_W'(2);
  localparam logic signed [ACC_W-1:0] ACC_THREE = ACC_W'(3);

  logic [COORD_BITS-1:0] cx_r, cy_r;
  logic [R-1:0]          rx_r, ry_r;
  logic [SX_W-1:0]       x_r;
  logic [R-1:0]          y_r;
  logic [CR_W-1:0]       crx_r, cry_r;
  logic signed [DEC_W-1:0] dec_r;
  logic [SQ_W-1:0]       rx2_r, ry2_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [P_W-1:0]        p_r;
  logic                  r2_r, active_r;

  logic [MA_W-1:0] ma;
  logic [MB_W-1:0] mb;
  logic [R+1:0]    a_odd;
  logic [R-1:0]    b_mag;

  // multiplier operands
  always_comb begin
    a_odd = {x_r, 1'b1};
    b_mag = (y_r == '0) ? R'(1) : (y_r - R'(1));
    case (cmd.mul_sel)
      MUL_RXRX: begin
        ma = MA_W'(rx_r);
        mb = MB_W'(rx_r);
      end
      MUL_RYRY: begin
        ma = MA_W'(ry_r);
        mb = MB_W'(ry_r);
      end
      MUL_RX2RY: begin
        ma = MA_W'(rx2_r);
        mb = MB_W'(ry_r);
      end
      MUL_AA: begin
        ma = MA_W'(a_odd);
        mb = MB_W'(a_odd);
      end
      MUL_RY2P: begin
        ma = p_r[MA_W-1:0];
        mb = ry2_r;
      end
      MUL_BB: begin
        ma = MA_W'(b_mag);
        mb = MB_W'(b_mag);
      end
      MUL_RX2P: begin
        ma = p_r[MA_W-1:0];
        mb = rx2_r;
      end
      MUL_RX2RY2: begin
        ma = MA_W'(rx2_r);
        mb = ry2_r;
      end
      default: begin
        ma = MA_W'(rx_r);
        mb = MB_W'(rx_r);
      end
    endcase
  end

  // accumulator operands and quarter-unit rounding toward zero
  logic signed [ACC_W-1:0] p_ext, rx2_ext, ry2_ext, acc_rnd, acc_q;
  assign p_ext   = signed'(ACC_W'(p_r));
  assign rx2_ext = signed'(ACC_W'(rx2_r));
  assign ry2_ext = signed'(ACC_W'(ry2_r));
  assign acc_rnd = acc_r + ACC_THREE;
  assign acc_q   = acc_r[ACC_W-1] ? (acc_rnd >>> 2) : (acc_r >>> 2);

  // one midpoint step
  logic [CR_W-1:0] crx_step, cry_step;
  logic            inc_x, dec_y;
  logic signed [DEC_W-1:0] dec_nxt, base_sx, crx_sx, cry_sx;
  assign crx_step = crx_r + CR_W'({ry2_r, 1'b0});
  assign cry_step = cry_r - CR_W'({rx2_r, 1'b0});
  assign inc_x    = r2_r ? !(dec_r > 0) : 1'b1;
  assign dec_y    = r2_r ? 1'b1 : !(dec_r < 0);
  assign base_sx  = signed'(DEC_W'(r2_r ? rx2_r : ry2_r));
  assign crx_sx   = inc_x ? signed'(DEC_W'(crx_step)) : '0;
  assign cry_sx   = dec_y ? signed'(DEC_W'(cry_step)) : '0;
  assign dec_nxt  = dec_r + base_sx + crx_sx - cry_sx;

  // walk and arithmetic registers
  always_ff @(posedge clk) begin
    p_r <= ma * mb;
    if (cmd.load_start) begin
      cx_r  <= in_center_x;
      cy_r  <= in_center_y;
      rx_r  <= in_radius_x;
      ry_r  <= in_radius_y;
      x_r   <= '0;
      y_r   <= in_radius_y;
      crx_r <= '0;
    end else if (cmd.do_step) begin
      if (inc_x) begin
        x_r   <= x_r + SX_W'(1);
        crx_r <= crx_step;
      end
      if (dec_y) begin
        y_r   <= y_r - R'(1);
        cry_r <= cry_step;
      end
      dec_r <= dec_nxt;
    end
    case (cmd.wr_sel)
      WR_RX2:       rx2_r <= p_r[SQ_W-1:0];
      WR_RY2:       ry2_r <= p_r[SQ_W-1:0];
      WR_START_ACC: begin
        cry_r <= {p_r[CR_W-2:0], 1'b0};
        acc_r <= (ry2_ext <<< 2) + rx2_ext + ACC_TWO - (p_ext <<< 2);
      end
      WR_ACC_P:     acc_r <= p_ext;
      WR_ACC_ADD:   acc_r <= acc_r + (p_ext <<< 2);
      WR_ACC_FIN:   acc_r <= acc_r - (p_ext <<< 2) + ACC_TWO;
      WR_DEC,
      WR_DEC_R2:    dec_r <= acc_q[DEC_W-1:0];
      default: ;
    endcase
  end

  // region and activity flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r2_r     <= 1'b0;
      active_r <= 1'b0;
    end else begin
      if (cmd.load_start) begin
        r2_r <= 1'b0;
      end else if (cmd.wr_sel == WR_DEC_R2) begin
        r2_r <= 1'b1;
      end
      if (cmd.upd_active) begin
        active_r <= !sts.done;
      end
    end
  end

  assign sts.active     = active_r;
  assign sts.switch_req = !r2_r && !(crx_r < cry_r);
  assign sts.done       = r2_r && (y_r == '0);

  // point generator, order (+x,+y) (-x,+y) (+x,-y) (-x,-y)
  logic signed [EXT_W-1:0] cxe, cye, offx, offy, sumx, sumy;
  assign cxe  = signed'(EXT_W'(cx_r));
  assign cye  = signed'(EXT_W'(cy_r));
  assign offx = signed'(EXT_W'({x_r, 2'b00}));
  assign offy = signed'(EXT_W'({y_r, 2'b00}));
  assign sumx = cmd.pt_idx[0] ? (cxe - offx) : (cxe + offx);
  assign sumy = cmd.pt_idx[1] ? (cye - offy) : (cye + offy);

  assign out_pixel_x      = signed'(sumx[PIX_W-1:0]);
  assign out_pixel_y      = signed'(sumy[PIX_W-1:0]);
  assign out_last_point   = (cmd.pt_idx == 2'd3);
  assign out_ellipse_done = sts.done;

`ifndef SYNTHESIS
  // region 2 is left only through a new start
  a_r2_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    r2_r && !cmd.load_start |=> r2_r)
    else $error("region flag dropped without a start");

  // a walk step is only issued on a live ellipse
  a_step_active: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_step |-> active_r)
    else $error("step issued while idle");
`endif

endmodule

[design/mer_ctrl.sv]
// ----------------------------------------------------------------------------
// mer_ctrl
// Controller: accepts items, sequences the shared multiplier for the start
// and region-switch values, and walks the four output beats of each step.
// ----------------------------------------------------------------------------
module mer_ctrl import mer_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     in_opcode,
  output logic     out_valid,
  input  logic     out_stall,
  input  mer_sts_t sts,
  output mer_cmd_t cmd
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SQX   = 4'd1;
  localparam logic [3:0] ST_SQY   = 4'd2;
  localparam logic [3:0] ST_CRY   = 4'd3;
  localparam logic [3:0] ST_SACC  = 4'd4;
  localparam logic [3:0] ST_SDEC  = 4'd5;
  localparam logic [3:0] ST_CHECK = 4'd6;
  localparam logic [3:0] ST_AA    = 4'd7;
  localparam logic [3:0] ST_YA    = 4'd8;
  localparam logic [3:0] ST_BB    = 4'd9;
  localparam logic [3:0] ST_XB    = 4'd10;
  localparam logic [3:0] ST_XY    = 4'd11;
  localparam logic [3:0] ST_RACC  = 4'd12;
  localparam logic [3:0] ST_RDEC  = 4'd13;
  localparam logic [3:0] ST_EMIT  = 4'd14;

  localparam logic OP_START = 1'b0;

  logic [3:0] state_r, state_nxt;
  logic [1:0] pt_r, pt_nxt;
  logic       in_acc, out_acc;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    pt_nxt         = pt_r;
    cmd.load_start = 1'b0;
    cmd.do_step    = 1'b0;
    cmd.mul_sel    = MUL_RXRX;
    cmd.wr_sel     = WR_NONE;
    cmd.upd_active = 1'b0;
    cmd.pt_idx     = pt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_opcode == OP_START) begin
            cmd.load_start = 1'b1;
            state_nxt      = ST_SQX;
          end else if (sts.active) begin
            cmd.do_step = 1'b1;
            state_nxt   = ST_CHECK;
          end
        end
      end
      ST_SQX: begin
        cmd.mul_sel = MUL_RXRX;
        state_nxt   = ST_SQY;
      end
      ST_SQY: begin
        cmd.mul_sel = MUL_RYRY;
        cmd.wr_sel  = WR_RX2;
        state_nxt   = ST_CRY;
      end
      ST_CRY: begin
        cmd.mul_sel = MUL_RX2RY;
        cmd.wr_sel  = WR_RY2;
        state_nxt   = ST_SACC;
      end
      ST_SACC: begin
        cmd.wr_sel = WR_START_ACC;
        state_nxt  = ST_SDEC;
      end
      ST_SDEC: begin
        cmd.wr_sel = WR_DEC;
        state_nxt  = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = sts.switch_req ? ST_AA : ST_EMIT;
      end
      // region-2 start value: ry2*(2x+1)^2 + 4*rx2*(y-1)^2 - 4*rx2*ry2 + 2
      ST_AA: begin
        cmd.mul_sel = MUL_AA;
        state_nxt   = ST_YA;
      end
      ST_YA: begin
        cmd.mul_sel = MUL_RY2P;
        state_nxt   = ST_BB;
      end
      ST_BB: begin
        cmd.mul_sel = MUL_BB;
        cmd.wr_sel  = WR_ACC_P;
        state_nxt   = ST_XB;
      end
      ST_XB: begin
        cmd.mul_sel = MUL_RX2P;
        state_nxt   = ST_XY;
      end
      ST_XY: begin
        cmd.mul_sel = MUL_RX2RY2;
        cmd.wr_sel  = WR_ACC_ADD;
        state_nxt   = ST_RACC;
      end
      ST_RACC: begin
        cmd.wr_sel = WR_ACC_FIN;
        state_nxt  = ST_RDEC;
      end
      ST_RDEC: begin
        cmd.wr_sel = WR_DEC_R2;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_acc) begin
          pt_nxt = pt_r + 2'd1;
          if (pt_r == 2'd3) begin
            cmd.upd_active = 1'b1;
            state_nxt      = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pt_r    <= 2'd0;
    end else begin
      state_r <= state_nxt;
      pt_r    <= pt_nxt;
    end
  end

`ifndef SYNTHESIS
  // no new item is taken while points are still going out
  a_in_closed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open during emission");

  // the fourth beat ends the emission
  a_four_beats: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && (pt_r == 2'd3) |=> !out_valid)
    else $error("emission ran past four beats");

  // points only go out once the region switch is settled
  a_settled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !sts.switch_req)
    else $error("emitting with region switch pending");
`endif

endmodule

[design/midpoint_ellipse_rasterizer.sv]
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer
// Two-region midpoint ellipse walker: a start item loads centre and radii,
// each step item advances one step; every live item gives four mirrored
// points at centre plus or minus 4x, 4y.
// ----------------------------------------------------------------------------
//  channel  | direction | ports                                   | beat
//  in_      | input     | valid, stall, opcode, center_x/y,       | one item
//           |           | radius_x/y                              |
//  out_     | output    | valid, stall, pixel_x/y, last_point,    | one point,
//           |           | ellipse_done                            | four per item
//
//  step item: accept, check state, then four output beats (out_stall can hold each)
//  start item: accept, multiply/setup states SQX, SQY, CRY, SACC, SDEC, check, then four beats
//  region switch adds states AA, YA, BB, XB, XY, RACC, RDEC on the single shared multiplier
//  a step on an idle walker is accepted and gives nothing
//  reset is synchronous on rst_n; out_stall holds the current point
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer import mer_pkg::*; #(
  parameter int RADIUS_BITS = 8,
  parameter int COORD_BITS  = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_opcode,
  input  logic [COORD_BITS-1:0]   in_center_x,
  input  logic [COORD_BITS-1:0]   in_center_y,
  input  logic [RADIUS_BITS-1:0]  in_radius_x,
  input  logic [RADIUS_BITS-1:0]  in_radius_y,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [PIX_W-1:0] out_pixel_x,
  output logic signed [PIX_W-1:0] out_pixel_y,
  output logic                    out_last_point,
  output logic                    out_ellipse_done
);

  mer_cmd_t cmd;
  mer_sts_t sts;

  // sequencer
  mer_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_opcode (in_opcode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic and point generation
  mer_dp #(
    .RADIUS_BITS (RADIUS_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_center_x      (in_center_x),
    .in_center_y      (in_center_y),
    .in_radius_x      (in_radius_x),
    .in_radius_y      (in_radius_y),
    .cmd              (cmd),
    .sts              (sts),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_last_point   (out_last_point),
    .out_ellipse_done (out_ellipse_done)
  );

endmodule
